/* rtl/core/multi_channel_heartbeat_watchdog_defines.svh */
// ----------------------------------------------------------------------------
// Heartbeat watchdog assertion macros
// Shared concurrent assertion forms used by the watchdog RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hbw_pkg.sv */
// ----------------------------------------------------------------------------
// Heartbeat watchdog package
// Sizes, codes and interface types shared by the watchdog modules.
// ----------------------------------------------------------------------------
package hbw_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int TIME_BITS    = 16;
  localparam int LIMIT_W      = 16;
  localparam int MASK_W       = 8;
  localparam int CHAN_W       = 3;
  localparam int SEQ_W        = 8;
  localparam int STATUS_W     = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CMP_W        = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  localparam logic [SEQ_W-1:0]    FIRST_VALUE = 8'd42;
  localparam logic [STATUS_W-1:0] STATUS_OK   = 8'd13;
  localparam logic [STATUS_W-1:0] STATUS_KILL = 8'd255;

  localparam logic [LIMIT_W-1:0] HB_LIMIT_RST  = 16'd100;
  localparam logic [LIMIT_W-1:0] HS_LIMIT_RST  = 16'd200;
  localparam logic [MASK_W-1:0]  REQ_MASK_RST  = 8'd126;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HB_LIMIT = 2'd0,
    CFG_HS_LIMIT = 2'd1,
    CFG_REQ_MASK = 2'd2,
    CFG_UNUSED   = 2'd3
  } hbw_cfg_e;

  typedef enum logic {
    REQ_TICK      = 1'b0,
    REQ_HEARTBEAT = 1'b1
  } hbw_req_e;

  typedef logic [TIME_BITS-1:0] hbw_time_t;
  typedef logic [CMP_W-1:0]     hbw_cmp_t;

  typedef struct packed {
    logic tick;
    logic hb_write;
  } hbw_chan_ctrl_t;

  typedef struct packed {
    logic started;
    logic seq_next_ok;
    logic timed_out;
  } hbw_chan_stat_t;

  typedef struct packed {
    logic                handshake_done;
    logic                failed;
    logic [STATUS_W-1:0] status_code;
  } hbw_result_t;

endpackage

/* rtl/core/hbw_channel.sv */
// ----------------------------------------------------------------------------
// Heartbeat watchdog channel
// Per-channel start flag, last sequence byte and saturating age counter.
// ----------------------------------------------------------------------------
module hbw_channel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hbw_pkg::hbw_chan_ctrl_t       ctrl_i,
  input  logic [hbw_pkg::SEQ_W-1:0]     seq_i,
  input  logic [hbw_pkg::LIMIT_W-1:0]   hb_limit_i,
  output hbw_pkg::hbw_chan_stat_t       stat_o
);

  logic                      started_q, started_d;
  logic [hbw_pkg::SEQ_W-1:0] last_q, last_d;
  hbw_pkg::hbw_time_t        age_q, age_d;
  hbw_pkg::hbw_time_t        age_inc;

  assign age_inc = (age_q == '1) ? age_q : age_q + 1'b1;

  always_comb begin
    started_d = started_q;
    last_d    = last_q;
    age_d     = age_q;
    if (ctrl_i.hb_write) begin
      started_d = 1'b1;
      last_d    = seq_i;
      age_d     = '0;
    end else if (ctrl_i.tick) begin
      age_d = age_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      age_q     <= '0;
    end else begin
      started_q <= started_d;
      last_q    <= last_d;
      age_q     <= age_d;
    end
  end

  assign stat_o.started     = started_q;
  assign stat_o.seq_next_ok = (seq_i == last_q + 1'b1);
  assign stat_o.timed_out   = hbw_pkg::hbw_cmp_t'(age_inc) > hbw_pkg::hbw_cmp_t'(hb_limit_i);

endmodule

/* rtl/core/hbw_out_reg.sv */
// ----------------------------------------------------------------------------
// Heartbeat watchdog output register
// Holds one status result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hbw_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  hbw_pkg::hbw_result_t  result_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  take_i,
  output hbw_pkg::hbw_result_t  result_o
);

  logic                 valid_q, valid_d;
  hbw_pkg::hbw_result_t data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

/* rtl/core/multi_channel_heartbeat_watchdog.sv */
// ----------------------------------------------------------------------------
// Multi-channel heartbeat watchdog
// Checks the start-up handshake, heartbeat sequence and timeouts per channel.
// ----------------------------------------------------------------------------
// Each accepted item is held in the input register and is resolved against
// the watchdog state from there, so the block takes one item per cycle while
// no tick waits. A tick yields one status transfer on the master side and a
// heartbeat yields none; a tick waits in the input register only while the
// output register holds an untaken status. Status is 13 while healthy and
// 255 once a failure has latched; only reset clears a failure.
// ----------------------------------------------------------------------------
`include "multi_channel_heartbeat_watchdog_defines.svh"

module multi_channel_heartbeat_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [hbw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hbw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] channel, [10:3] sequence_req
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] status_code, [8] failed, [9] handshake_done
);

  localparam int N = hbw_pkg::NUM_CHANNELS;

  logic [hbw_pkg::LIMIT_W-1:0] hb_limit_q, hs_limit_q;
  logic [hbw_pkg::MASK_W-1:0]  req_mask_q;

  logic                        in_valid_q;
  hbw_pkg::hbw_req_e           in_type_q;
  logic [hbw_pkg::CHAN_W-1:0]  in_ch_q;
  logic [hbw_pkg::SEQ_W-1:0]   in_seq_q;

  logic               fail_q, fail_d;
  logic               hs_done_q, hs_done_d;
  hbw_pkg::hbw_time_t since_start_q, since_start_d;

  hbw_pkg::hbw_chan_ctrl_t ctrl[N];
  hbw_pkg::hbw_chan_stat_t stat[N];
  logic [N-1:0] hit_vec, started_vec, seq_ok_vec, tout_vec, req_vec;

  logic out_ready, proc_tick, proc_hb, hb_valid, first_ok, sel_started, sel_seq_ok;
  logic hs_fire, hs_fail, hs_new, tmo_fail, hb_fail, hb_hs_set;
  hbw_pkg::hbw_result_t result, result_out;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_limit_q <= hbw_pkg::HB_LIMIT_RST;
      hs_limit_q <= hbw_pkg::HS_LIMIT_RST;
      req_mask_q <= hbw_pkg::REQ_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (hbw_pkg::hbw_cfg_e'(cfg_idx_i))
        hbw_pkg::CFG_HB_LIMIT: hb_limit_q <= cfg_wdata_i[hbw_pkg::LIMIT_W-1:0];
        hbw_pkg::CFG_HS_LIMIT: hs_limit_q <= cfg_wdata_i[hbw_pkg::LIMIT_W-1:0];
        hbw_pkg::CFG_REQ_MASK: req_mask_q <= cfg_wdata_i[hbw_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign proc_tick     = in_valid_q && (in_type_q == hbw_pkg::REQ_TICK) && out_ready;
  assign proc_hb       = in_valid_q && (in_type_q == hbw_pkg::REQ_HEARTBEAT);
  assign s_axis_tready = !in_valid_q || proc_tick || proc_hb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_type_q <= hbw_pkg::hbw_req_e'(s_axis_tuser);
      in_ch_q   <= s_axis_tdata[hbw_pkg::CHAN_W-1:0];
      in_seq_q  <= s_axis_tdata[hbw_pkg::CHAN_W +: hbw_pkg::SEQ_W];
    end
  end

  // Channels
  assign first_ok = (in_seq_q == hbw_pkg::FIRST_VALUE);
  assign hb_valid = proc_hb && !fail_q && (|hit_vec);

  for (genvar g = 0; g < N; g++) begin : g_chan
    assign hit_vec[g] = (32'(in_ch_q) == 32'(g));
    if (g < hbw_pkg::MASK_W) begin : g_req
      assign req_vec[g] = req_mask_q[g];
    end else begin : g_noreq
      assign req_vec[g] = 1'b0;
    end
    assign ctrl[g].tick     = proc_tick;
    assign ctrl[g].hb_write = hb_valid && hit_vec[g] && (stat[g].started || first_ok);
    assign started_vec[g]   = stat[g].started;
    assign seq_ok_vec[g]    = stat[g].seq_next_ok;
    assign tout_vec[g]      = stat[g].timed_out;

    hbw_channel u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .seq_i      (in_seq_q),
      .hb_limit_i (hb_limit_q),
      .stat_o     (stat[g])
    );
  end

  assign sel_started = |(started_vec & hit_vec);
  assign sel_seq_ok  = |(seq_ok_vec & hit_vec);
  assign hb_fail     = hb_valid && (sel_started ? !sel_seq_ok : !first_ok);
  assign hb_hs_set   = hb_valid && !sel_started && !first_ok;

  // Tick evaluation
  assign since_start_d = (since_start_q == '1) ? since_start_q : since_start_q + 1'b1;
  assign hs_fire  = !hs_done_q && !fail_q &&
                    (hbw_pkg::hbw_cmp_t'(since_start_d) > hbw_pkg::hbw_cmp_t'(hs_limit_q));
  assign hs_fail  = hs_fire && (|(req_vec & ~started_vec));
  assign hs_new   = hs_done_q || hs_fire;
  assign tmo_fail = hs_new && (|((req_vec | started_vec) & tout_vec));

  always_comb begin
    fail_d    = fail_q;
    hs_done_d = hs_done_q;
    if (proc_tick) begin
      fail_d    = fail_q || hs_fail || tmo_fail;
      hs_done_d = hs_new;
    end else if (proc_hb) begin
      fail_d    = fail_q || hb_fail;
      hs_done_d = hs_done_q || hb_hs_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q        <= 1'b0;
      hs_done_q     <= 1'b0;
      since_start_q <= '0;
    end else begin
      fail_q    <= fail_d;
      hs_done_q <= hs_done_d;
      if (proc_tick) begin
        since_start_q <= since_start_d;
      end
    end
  end

  // Result
  assign result.status_code    = fail_d ? hbw_pkg::STATUS_KILL : hbw_pkg::STATUS_OK;
  assign result.failed         = fail_d;
  assign result.handshake_done = hs_done_d;

  hbw_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (proc_tick),
    .result_i (result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .result_o (result_out)
  );

  assign m_axis_tdata = {6'b0, result_out.handshake_done, result_out.failed,
                         result_out.status_code};

  `HBW_ASSERT_NEXT(a_fail_sticky, fail_q, fail_q, "failure latch cleared without reset")
  `HBW_ASSERT_NEXT(a_hs_sticky, hs_done_q, hs_done_q, "handshake done cleared without reset")
  `HBW_ASSERT_SAME(a_status_match, m_axis_tvalid,
                   (result_out.status_code == hbw_pkg::STATUS_KILL) == result_out.failed,
                   "status code disagrees with failed flag")
  `HBW_ASSERT_NEXT(a_started_grows, 1'b1,
                   (started_vec & $past(started_vec)) == $past(started_vec),
                   "a started channel lost its start flag")

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Heartbeat watchdog testbench
// Streams ticks and heartbeats into the watchdog and checks every status
// transfer against a cycle-free prediction of the watchdog state. A start-up
// handshake is followed by long healthy runs under several register settings,
// and the run ends with a sequence error and random traffic after the kill.
// Sender gaps and receiver stalls rotate through several paces.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHANNELS = hbw_pkg::NUM_CHANNELS;
  localparam int CHAN_W       = hbw_pkg::CHAN_W;
  localparam int SEQ_W        = hbw_pkg::SEQ_W;
  localparam int LIMIT_W      = hbw_pkg::LIMIT_W;
  localparam int MASK_W       = hbw_pkg::MASK_W;
  localparam int STATUS_W     = hbw_pkg::STATUS_W;
  localparam int CFG_IDX_W    = hbw_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = hbw_pkg::CFG_DATA_W;

  typedef struct packed {
    hbw_pkg::hbw_req_e kind;
    logic [CHAN_W-1:0] channel;
    logic [SEQ_W-1:0]  seq;
  } watchdog_item_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // [2:0] channel, [10:3] sequence_req
  logic                  s_axis_tuser  = 1'b0; // [0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;  // [7:0] status_code, [8] failed, [9] handshake_done

  logic [LIMIT_W-1:0]      cfg_hb_limit = hbw_pkg::HB_LIMIT_RST;
  logic [LIMIT_W-1:0]      cfg_hs_limit = hbw_pkg::HS_LIMIT_RST;
  logic [MASK_W-1:0]       cfg_req_mask = hbw_pkg::REQ_MASK_RST;

  logic                    wd_failed      = 1'b0;
  logic                    wd_hs_done     = 1'b0;
  hbw_pkg::hbw_time_t      wd_since_start = '0;
  logic [NUM_CHANNELS-1:0] wd_started     = '0;
  logic [SEQ_W-1:0]        wd_last_seq [NUM_CHANNELS];
  hbw_pkg::hbw_time_t      wd_age      [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] plan_started     = '0;
  logic [SEQ_W-1:0]        plan_seq [NUM_CHANNELS];
  int unsigned             plan_age [NUM_CHANNELS];
  int unsigned             plan_since_start = 0;
  logic                    plan_done        = 1'b0;

  watchdog_item_t       pending_items[$];
  hbw_pkg::hbw_result_t status_expected[$];
  int unsigned          items_in_flight = 0;
  int unsigned          errors          = 0;
  int unsigned          pace_cycle      = 0;

  multi_channel_heartbeat_watchdog u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) pace_cycle <= pace_cycle + 1;

  function automatic int unsigned send_idle_pct();
    case ((pace_cycle / 97) % 4)
      1: return 57;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case ((pace_cycle / 97) % 4)
      2: return 57;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  task automatic advance_watchdog(input watchdog_item_t item);
    hbw_pkg::hbw_result_t res;
    logic [SEQ_W-1:0]     next_seq;
    if (item.kind == hbw_pkg::REQ_HEARTBEAT) begin
      if (!wd_failed) begin
        if (!wd_started[item.channel]) begin
          if (item.seq == hbw_pkg::FIRST_VALUE) begin
            wd_started[item.channel]  = 1'b1;
            wd_last_seq[item.channel] = item.seq;
            wd_age[item.channel]      = '0;
          end else begin
            wd_failed  = 1'b1;
            wd_hs_done = 1'b1;
          end
        end else begin
          next_seq = wd_last_seq[item.channel] + 1'b1;
          if (item.seq != next_seq) wd_failed = 1'b1;
          wd_last_seq[item.channel] = item.seq;
          wd_age[item.channel]      = '0;
        end
      end
    end else begin
      if (wd_since_start != '1) wd_since_start = wd_since_start + 1'b1;
      for (int c = 0; c < NUM_CHANNELS; c++)
        if (wd_age[c] != '1) wd_age[c] = wd_age[c] + 1'b1;
      if (!wd_hs_done && !wd_failed && wd_since_start > cfg_hs_limit) begin
        for (int c = 0; c < NUM_CHANNELS; c++)
          if (cfg_req_mask[c] && !wd_started[c]) wd_failed = 1'b1;
        wd_hs_done = 1'b1;
      end
      if (wd_hs_done)
        for (int c = 0; c < NUM_CHANNELS; c++)
          if ((cfg_req_mask[c] || wd_started[c]) && wd_age[c] > cfg_hb_limit)
            wd_failed = 1'b1;
      res.status_code    = wd_failed ? hbw_pkg::STATUS_KILL : hbw_pkg::STATUS_OK;
      res.failed         = wd_failed;
      res.handshake_done = wd_hs_done;
      status_expected.push_back(res);
    end
  endtask

  function automatic logic [SEQ_W-1:0] heartbeat_value(input logic [CHAN_W-1:0] ch);
    return plan_started[ch] ? plan_seq[ch] + 1'b1 : hbw_pkg::FIRST_VALUE;
  endfunction

  task automatic queue_item(input hbw_pkg::hbw_req_e kind, input logic [CHAN_W-1:0] ch,
                            input logic [SEQ_W-1:0] seq);
    watchdog_item_t item;
    item.kind    = kind;
    item.channel = ch;
    item.seq     = seq;
    pending_items.push_back(item);
    items_in_flight++;
    if (kind == hbw_pkg::REQ_HEARTBEAT) begin
      if (plan_started[ch] || seq == hbw_pkg::FIRST_VALUE) begin
        plan_started[ch] = 1'b1;
        plan_seq[ch]     = seq;
        plan_age[ch]     = 0;
      end
    end else begin
      plan_since_start++;
      foreach (plan_age[c]) plan_age[c]++;
      if (plan_since_start > cfg_hs_limit) plan_done = 1'b1;
    end
  endtask

  // Refreshes every watched channel that would otherwise time out on this tick.
  task automatic queue_safe_tick();
    bit closing;
    closing = plan_done || (plan_since_start + 1 > cfg_hs_limit);
    if (closing)
      for (int c = 0; c < NUM_CHANNELS; c++)
        if ((cfg_req_mask[c] || plan_started[c]) &&
            (!plan_started[c] || plan_age[c] >= cfg_hb_limit))
          queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(c), heartbeat_value(CHAN_W'(c)));
    queue_item(hbw_pkg::REQ_TICK, CHAN_W'($urandom_range(NUM_CHANNELS - 1)),
               SEQ_W'($urandom_range(255)));
  endtask

  task automatic queue_traffic(input int n, input int unsigned hb_pct,
                               input int unsigned focus_pct);
    logic [CHAN_W-1:0] ch;
    repeat (n) begin
      if ($urandom_range(99) < hb_pct) begin
        ch = ($urandom_range(99) < focus_pct) ? CHAN_W'(3)
                                              : CHAN_W'($urandom_range(NUM_CHANNELS - 1));
        queue_item(hbw_pkg::REQ_HEARTBEAT, ch, heartbeat_value(ch));
      end else begin
        queue_safe_tick();
      end
    end
  endtask

  task automatic write_reg(input hbw_pkg::hbw_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      hbw_pkg::CFG_HB_LIMIT: cfg_hb_limit = data;
      hbw_pkg::CFG_HS_LIMIT: cfg_hs_limit = data;
      hbw_pkg::CFG_REQ_MASK: cfg_req_mask = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_in_flight != 0 || status_expected.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    watchdog_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        item.kind    = hbw_pkg::hbw_req_e'(s_axis_tuser);
        item.channel = s_axis_tdata[CHAN_W-1:0];
        item.seq     = s_axis_tdata[CHAN_W +: SEQ_W];
        advance_watchdog(item);
        items_in_flight--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(16 - CHAN_W - SEQ_W){1'b0}}, item.seq, item.channel};
          s_axis_tuser  <= item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : status_monitor
    hbw_pkg::hbw_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_expected.size() == 0) begin
          $display("%0t: status transfer with none expected, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = status_expected.pop_front();
          if (m_axis_tdata[STATUS_W-1:0] !== want.status_code) begin
            $display("%0t: status_code expected %0d, got %0d", $time, want.status_code,
                     m_axis_tdata[STATUS_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[STATUS_W] !== want.failed) begin
            $display("%0t: failed expected %b, got %b", $time, want.failed,
                     m_axis_tdata[STATUS_W]);
            errors++;
          end
          if (m_axis_tdata[STATUS_W+1] !== want.handshake_done) begin
            $display("%0t: handshake_done expected %b, got %b", $time, want.handshake_done,
                     m_axis_tdata[STATUS_W+1]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  initial begin
    foreach (wd_last_seq[c]) begin
      wd_last_seq[c] = '0;
      wd_age[c]      = '0;
      plan_seq[c]    = '0;
      plan_age[c]    = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Handshake under the reset settings, with a tick before any channel starts.
    queue_item(hbw_pkg::REQ_TICK, CHAN_W'(7), SEQ_W'(255));
    for (int c = 1; c < 7; c++)
      queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(c), hbw_pkg::FIRST_VALUE);
    queue_item(hbw_pkg::REQ_TICK, '0, '0);
    queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(1), heartbeat_value(CHAN_W'(1)));
    queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(1), heartbeat_value(CHAN_W'(1)));
    queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(6), heartbeat_value(CHAN_W'(6)));
    repeat (3) queue_safe_tick();
    while (!plan_done) queue_traffic(1, 25, 50);
    queue_traffic(10, 40, 50);

    wait_idle();
    write_reg(hbw_pkg::CFG_HB_LIMIT, 16'd3);
    write_reg(hbw_pkg::CFG_REQ_MASK, {8'($urandom_range(255)), 8'h00});
    write_reg(hbw_pkg::CFG_HS_LIMIT, 16'hFFFF);
    write_reg(hbw_pkg::CFG_UNUSED, 16'($urandom_range(65535)));
    finish_writes();
    queue_traffic(40, 40, 20);

    wait_idle();
    write_reg(hbw_pkg::CFG_HB_LIMIT, 16'hFFFF);
    write_reg(hbw_pkg::CFG_REQ_MASK, {8'($urandom_range(255)), 8'hFF});
    finish_writes();
    queue_traffic(50, 90, 85);

    wait_idle();
    write_reg(hbw_pkg::CFG_HB_LIMIT, 16'($urandom_range(40, 5)));
    write_reg(hbw_pkg::CFG_HS_LIMIT, 16'd0);
    write_reg(hbw_pkg::CFG_REQ_MASK, 16'($urandom_range(65535)));
    finish_writes();
    queue_traffic(50, 85, 85);

    // A skipped sequence value kills the watchdog; later traffic is random.
    wait_idle();
    write_reg(hbw_pkg::CFG_HB_LIMIT, 16'd0);
    write_reg(hbw_pkg::CFG_REQ_MASK, 16'($urandom_range(65535)));
    finish_writes();
    queue_item(hbw_pkg::REQ_HEARTBEAT, CHAN_W'(3), plan_seq[3] + 8'd2);
    queue_item(hbw_pkg::REQ_TICK, '0, '0);
    repeat (30)
      queue_item(hbw_pkg::hbw_req_e'($urandom_range(1)),
                 CHAN_W'($urandom_range(NUM_CHANNELS - 1)), SEQ_W'($urandom_range(255)));

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
